/* design/ccpp_pkg.sv */
// Package: shared types and codes of the constant pool parser.
`default_nettype none
package ccpp_pkg;

   // parse phase
   typedef enum logic [1:0] {
      PH_TAG     = 2'd0,
      PH_FIELD   = 2'd1,
      PH_REFKIND = 2'd2,
      PH_TEXT    = 2'd3
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_ENTRY = 2'd0;
   localparam logic [1:0] KIND_TEXT  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // constant pool tags
   localparam logic [7:0] TAG_UTF8        = 8'd1;
   localparam logic [7:0] TAG_INTEGER     = 8'd3;
   localparam logic [7:0] TAG_FLOAT       = 8'd4;
   localparam logic [7:0] TAG_LONG        = 8'd5;
   localparam logic [7:0] TAG_DOUBLE      = 8'd6;
   localparam logic [7:0] TAG_CLASS       = 8'd7;
   localparam logic [7:0] TAG_STRING      = 8'd8;
   localparam logic [7:0] TAG_FIELDREF    = 8'd9;
   localparam logic [7:0] TAG_METHODREF   = 8'd10;
   localparam logic [7:0] TAG_IFMETHODREF = 8'd11;
   localparam logic [7:0] TAG_NAMETYPE    = 8'd12;
   localparam logic [7:0] TAG_METHODHDL   = 8'd15;
   localparam logic [7:0] TAG_METHODTYPE  = 8'd16;
   localparam logic [7:0] TAG_INVOKEDYN   = 8'd18;

   // result payload
   typedef struct packed {
      logic [7:0]  text_byte;
      logic [7:0]  ref_kind;
      logic [15:0] index_second;
      logic [15:0] index_first;
      logic [63:0] value;
      logic [7:0]  tag;
      logic [15:0] entry_index;
   } rsp_data_type;

endpackage
`default_nettype wire

/* design/class_constant_pool_parser_top.sv */
// Top level: streaming parser of the constant pool of a Java class file.
`default_nettype none
// Takes the constant pool region one byte per transaction on req_ and gives at
// most one result transaction per byte on rsp_. Throughput is one byte per
// clock while results are taken: a byte is captured in an input register,
// decoded against the parse state by combinational logic, and its result
// lands in an output register. While a result waits for rsp_tready the input
// register holds one more byte and req_tready then drops, also for bytes that
// give no result. Entries are numbered from
// 1 to pool_count-1; long and double take two slots. req_tuser marks the first
// byte of a pool and restarts the parse at any point. Once the last entry
// closes (rsp_tuser pool_done), or while the slot number is not below
// pool_count, bytes are swallowed without a result until the next restart.
// pool_count is written on the csr_ channel, which is always ready; write it
// while the block is idle.
module class_constant_pool_parser_top
   import ccpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // configuration
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data,      // pool_count
   // byte stream in
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,     // byte_value
   input  wire logic [0:0]   req_tuser,     // first_byte
   // results out
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,     // entry_index, tag, value, index_first,
                                            // index_second, ref_kind, text_byte
   output logic [2:0]        rsp_tuser,     // kind[1:0], pool_done
   output logic              rsp_tlast      // entry_end
);

   // configuration register
   logic [15:0] pool_count_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [15:0] left_ff, left_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] held_index_ff, held_index_in;
   logic [7:0]  held_kind_ff, held_kind_in;
   logic [15:0] slot_ff, slot_in;
   logic        done_ff, done_in;

   // output register
   logic         out_valid_ff;
   rsp_data_type out_data_ff, out_data_in;
   logic [1:0]   out_kind_ff, out_kind_in;
   logic         out_end_ff, out_end_in;
   logic         out_done_ff, out_done_in;
   logic         emit;

   // decode stage moves when the output slot is free or being drained
   logic advance;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff <= '0;
      end else if (csr_valid) begin
         pool_count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
      end
   end

   // byte decode against the parse state
   always_comb begin
      logic [16:0] next_slot;
      logic [15:0] lo;
      logic [15:0] hi;
      logic        fin;
      logic        two_slots;

      // restart comes first
      if (in_first_ff) begin
         phase_in      = PH_TAG;
         tag_in        = '0;
         left_in       = '0;
         acc_in        = '0;
         held_index_in = '0;
         held_kind_in  = '0;
         slot_in       = 16'd1;
         done_in       = 1'b0;
      end else begin
         phase_in      = phase_ff;
         tag_in        = tag_ff;
         left_in       = left_ff;
         acc_in        = acc_ff;
         held_index_in = held_index_ff;
         held_kind_in  = held_kind_ff;
         slot_in       = slot_ff;
         done_in       = done_ff;
      end

      emit        = 1'b0;
      fin         = 1'b0;
      out_kind_in = KIND_ENTRY;
      out_data_in = '0;
      lo          = '0;
      hi          = '0;

      if (!done_in && (slot_in < pool_count_ff)) begin
         case (phase_in)
            PH_TAG: begin
               tag_in        = in_byte_ff;
               acc_in        = '0;
               held_kind_in  = '0;
               held_index_in = '0;
               case (in_byte_ff)
                  TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
                     left_in  = 16'd2;
                     phase_in = PH_FIELD;
                  end
                  TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
                  TAG_IFMETHODREF, TAG_NAMETYPE, TAG_INVOKEDYN: begin
                     left_in  = 16'd4;
                     phase_in = PH_FIELD;
                  end
                  TAG_LONG, TAG_DOUBLE: begin
                     left_in  = 16'd8;
                     phase_in = PH_FIELD;
                  end
                  TAG_METHODHDL: begin
                     phase_in = PH_REFKIND;
                  end
                  default: begin
                     emit        = 1'b1;
                     fin         = 1'b1;
                     out_kind_in = KIND_ERROR;
                  end
               endcase
            end
            PH_REFKIND: begin
               held_kind_in = in_byte_ff;
               left_in      = 16'd2;
               phase_in     = PH_FIELD;
            end
            PH_FIELD: begin
               acc_in = {acc_in[55:0], in_byte_ff};
               if (left_in != '0) left_in = left_in - 16'd1;
               if (left_in == '0) begin
                  lo   = acc_in[15:0];
                  hi   = acc_in[31:16];
                  emit = 1'b1;
                  fin  = 1'b1;
                  case (tag_in)
                     TAG_UTF8: begin
                        held_index_in = lo;
                        if (lo != '0) begin
                           fin                 = 1'b0;
                           phase_in            = PH_TEXT;
                           left_in             = lo;
                           out_data_in.value   = {48'd0, lo};
                        end
                     end
                     TAG_INTEGER, TAG_FLOAT: begin
                        out_data_in.value = {32'd0, acc_in[31:0]};
                     end
                     TAG_LONG, TAG_DOUBLE: begin
                        out_data_in.value = acc_in;
                     end
                     TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
                        out_data_in.index_first = lo;
                     end
                     TAG_METHODHDL: begin
                        out_data_in.index_first = lo;
                        out_data_in.ref_kind    = held_kind_in;
                     end
                     default: begin
                        out_data_in.index_first  = hi;
                        out_data_in.index_second = lo;
                     end
                  endcase
               end
            end
            PH_TEXT: begin
               if (left_in != '0) left_in = left_in - 16'd1;
               emit                  = 1'b1;
               out_kind_in           = KIND_TEXT;
               out_data_in.value     = {48'd0, held_index_in};
               out_data_in.text_byte = in_byte_ff;
               fin                   = (left_in == '0);
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase
      end

      out_data_in.entry_index = slot_in;
      out_data_in.tag         = tag_in;
      out_end_in              = fin;
      out_done_in             = 1'b0;

      // closing an entry moves the slot number on
      two_slots = (out_kind_in == KIND_ENTRY) &&
                  ((tag_in == TAG_LONG) || (tag_in == TAG_DOUBLE));
      next_slot = {1'b0, slot_in} + (two_slots ? 17'd2 : 17'd1);
      if (fin) begin
         if (next_slot >= {1'b0, pool_count_ff}) begin
            done_in     = 1'b1;
            out_done_in = 1'b1;
         end
         slot_in  = next_slot[15:0];
         phase_in = PH_TAG;
         left_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TAG;
         tag_ff        <= '0;
         left_ff       <= '0;
         acc_ff        <= '0;
         held_index_ff <= '0;
         held_kind_ff  <= '0;
         slot_ff       <= 16'd1;
         done_ff       <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         tag_ff        <= tag_in;
         left_ff       <= left_in;
         acc_ff        <= acc_in;
         held_index_ff <= held_index_in;
         held_kind_ff  <= held_kind_in;
         slot_ff       <= slot_in;
         done_ff       <= done_in;
      end
   end

   // result register: loaded only when its previous transaction is gone
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_data_ff <= out_data_in;
         out_kind_ff <= out_kind_in;
         out_end_ff  <= out_end_in;
         out_done_ff <= out_done_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_done_ff, out_kind_ff};
   assign rsp_tlast  = out_end_ff;

endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for the constant pool parser: predicts each result byte by byte and compares it.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccpp_pkg::*;

   // Generous bound. The slowest correct run is well under 1k bytes, each
   // waiting out a sender gap plus a receiver stall.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 100;

   // Tags that the parser decodes. Any other byte in tag position is an error entry.
   localparam logic [7:0] KNOWN_TAGS [14] = '{
      TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS, TAG_STRING,
      TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF, TAG_NAMETYPE, TAG_METHODHDL,
      TAG_METHODTYPE, TAG_INVOKEDYN
   };

   // One result as the parser reports it, unpacked from tdata, tuser and tlast.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] entry_index;
      logic [7:0]  tag;
      logic [63:0] value;
      logic [15:0] index_first;
      logic [15:0] index_second;
      logic [7:0]  ref_kind;
      logic [7:0]  text_byte;
      logic        entry_end;
      logic        pool_done;
   } pool_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   class_constant_pool_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Parser prediction: own copy of pool_count and the parse state
   // ---------------------------------------------------------------------
   logic [15:0] pool_cnt;
   phase_type   ph;
   logic [7:0]  cur_tag;
   logic [7:0]  held_ref_kind;
   logic [15:0] remaining;     // field bytes, or text bytes in PH_TEXT
   logic [15:0] utf_len;
   logic [15:0] slot;
   logic [63:0] acc;
   logic        pool_finished;

   pool_result_type pending_results [$];   // expected results, oldest first
   logic [8:0]   stim_q [$];            // {first_byte, byte_value} waiting to go out
   int           mismatches = 0;
   int           live_bytes = 0;        // bytes that the parser did not swallow
   int           cycle_count = 0;
   int           burst_left = 0;
   bit           gaps_on = 1'b1;

   function automatic void restart_parse();
      ph            = PH_TAG;
      cur_tag       = '0;
      remaining     = '0;
      acc           = '0;
      utf_len       = '0;
      held_ref_kind = '0;
      slot          = 16'd1;
      pool_finished = 1'b0;
   endfunction

   // Build a result from the current entry. Closing it advances the slot:
   // long and double take two slots, and reaching pool_count ends the pool.
   function automatic pool_result_type make_result(input logic [1:0] k, input logic [63:0] v,
                                                input logic [15:0] i1, input logic [15:0] i2,
                                                input logic [7:0] rk, input logic [7:0] tb_byte,
                                                input logic last);
      pool_result_type r;
      logic [16:0]  next_slot;
      r              = '0;
      r.kind         = k;
      r.entry_index  = slot;
      r.tag          = cur_tag;
      r.value        = v;
      r.index_first  = i1;
      r.index_second = i2;
      r.ref_kind     = rk;
      r.text_byte    = tb_byte;
      r.entry_end    = last;
      if (last) begin
         next_slot = {1'b0, slot} +
                     ((k == KIND_ENTRY && (cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE)) ?
                      17'd2 : 17'd1);
         if (next_slot >= {1'b0, pool_cnt}) begin
            pool_finished = 1'b1;
            r.pool_done   = 1'b1;
         end
         slot      = next_slot[15:0];
         ph        = PH_TAG;
         remaining = '0;
      end
      return r;
   endfunction

   // Advance the parse by one byte. Returns 1 when the byte yields a result;
   // used is 0 when the byte was swallowed (pool finished or slot not below pool_count).
   function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                     output pool_result_type r, output bit used);
      r    = '0;
      used = 1'b0;
      if (first) restart_parse();
      if (pool_finished || slot >= pool_cnt) return 1'b0;
      used = 1'b1;
      case (ph)
         PH_TAG: begin
            cur_tag       = b;
            acc           = '0;
            held_ref_kind = '0;
            utf_len       = '0;
            case (b)
               TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
                  remaining = 16'd2;
                  ph        = PH_FIELD;
               end
               TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF,
               TAG_NAMETYPE, TAG_INVOKEDYN: begin
                  remaining = 16'd4;
                  ph        = PH_FIELD;
               end
               TAG_LONG, TAG_DOUBLE: begin
                  remaining = 16'd8;
                  ph        = PH_FIELD;
               end
               TAG_METHODHDL: ph = PH_REFKIND;
               default: begin
                  r = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b1);
                  return 1'b1;
               end
            endcase
            return 1'b0;
         end
         PH_REFKIND: begin
            held_ref_kind = b;
            remaining     = 16'd2;
            ph            = PH_FIELD;
            return 1'b0;
         end
         PH_FIELD: begin
            acc = {acc[55:0], b};
            if (remaining != 0) remaining--;
            if (remaining != 0) return 1'b0;
            case (cur_tag)
               TAG_UTF8: begin
                  utf_len = acc[15:0];
                  if (acc[15:0] == 0) begin
                     r = make_result(KIND_ENTRY, '0, '0, '0, '0, '0, 1'b1);
                  end else begin
                     // header first, text bytes follow
                     ph        = PH_TEXT;
                     remaining = acc[15:0];
                     r = make_result(KIND_ENTRY, {48'd0, acc[15:0]}, '0, '0, '0, '0, 1'b0);
                  end
               end
               TAG_INTEGER, TAG_FLOAT:
                  r = make_result(KIND_ENTRY, {32'd0, acc[31:0]}, '0, '0, '0, '0, 1'b1);
               TAG_LONG, TAG_DOUBLE:
                  r = make_result(KIND_ENTRY, acc, '0, '0, '0, '0, 1'b1);
               TAG_CLASS, TAG_STRING, TAG_METHODTYPE:
                  r = make_result(KIND_ENTRY, '0, acc[15:0], '0, '0, '0, 1'b1);
               TAG_METHODHDL:
                  r = make_result(KIND_ENTRY, '0, acc[15:0], '0, held_ref_kind, '0, 1'b1);
               default:
                  r = make_result(KIND_ENTRY, '0, acc[31:16], acc[15:0], '0, '0, 1'b1);
            endcase
            return 1'b1;
         end
         default: begin
            if (remaining != 0) remaining--;
            r = make_result(KIND_TEXT, {48'd0, utf_len}, '0, '0, '0, b, remaining == 0);
            return 1'b1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void push_byte(input logic [7:0] b, input logic f);
      stim_q.push_back({f, b});
   endfunction

   function automatic logic [7:0] pick_tag();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return KNOWN_TAGS[$urandom_range(0, 13)];
   endfunction

   // Well-formed entry for tag t with random field content.
   function automatic void push_entry(input logic [7:0] t, input logic f);
      int          n;
      logic [15:0] len;
      n = 0;
      push_byte(t, f);
      case (t)
         TAG_UTF8: begin
            case ($urandom_range(0, 9))
               0:       len = '0;
               9:       len = 16'($urandom_range(6, 40));
               default: len = 16'($urandom_range(1, 5));
            endcase
            push_byte(len[15:8], 1'b0);
            push_byte(len[7:0], 1'b0);
            n = int'(len);
         end
         TAG_CLASS, TAG_STRING, TAG_METHODTYPE:                    n = 2;
         TAG_METHODHDL:                                            n = 3;
         TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
         TAG_IFMETHODREF, TAG_NAMETYPE, TAG_INVOKEDYN:             n = 4;
         TAG_LONG, TAG_DOUBLE:                                     n = 8;
         default:                                                  n = 0;
      endcase
      repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   // One byte transaction. Bursts of random length, random gaps between them while gaps_on is set.
   task automatic send_byte(input logic [7:0] b, input logic f);
      pool_result_type r;
      bit           has_rsp;
      bit           used;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (gaps_on) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      has_rsp = parse_byte(b, f, r, used);
      if (has_rsp) pending_results.push_back(r);
      if (used) live_bytes++;
   endtask

   task automatic flush_stim();
      logic [8:0] item;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         send_byte(item[7:0], item[8]);
      end
   endtask

   // Idle: all results in, and a swallowed byte in the two-stage pipe has
   // also cleared.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_pool_count(input logic [15:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool_cnt = v;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // pool_count 0 (reset value) and 1: nothing may come out.
   task automatic test_empty_pool();
      push_entry(TAG_CLASS, 1'b1);
      push_entry(8'h00, 1'b0);
      flush_stim();
      set_pool_count(16'd1);
      push_entry(TAG_INTEGER, 1'b1);
      push_entry(TAG_UTF8, 1'b1);
      flush_stim();
   endtask

   // Every tag, UTF8 twice, with extreme field bytes, then unknown tags; the last
   // error entry closes the pool and the trailing tag is swallowed.
   task automatic test_all_tags();
      logic [7:0] seq [$];
      seq = '{TAG_UTF8, 8'h00, 8'h02, 8'h00, 8'hff,
              TAG_UTF8, 8'h00, 8'h00,
              TAG_INTEGER, 8'hff, 8'hff, 8'hff, 8'hff,
              TAG_FLOAT, 8'h7f, 8'h80, 8'h00, 8'h01,
              TAG_LONG, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
              TAG_DOUBLE, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
              TAG_CLASS, 8'hff, 8'hff,
              TAG_STRING, 8'h00, 8'h01,
              TAG_METHODTYPE, 8'h12, 8'h34,
              TAG_FIELDREF, 8'h00, 8'h01, 8'hff, 8'hfe,
              TAG_METHODREF, 8'hff, 8'hff, 8'h00, 8'h00,
              TAG_IFMETHODREF, 8'h12, 8'h34, 8'h56, 8'h78,
              TAG_NAMETYPE, 8'h80, 8'h01, 8'h7f, 8'hfe,
              TAG_INVOKEDYN, 8'h00, 8'h00, 8'hff, 8'hff,
              TAG_METHODHDL, 8'hff, 8'hab, 8'hcd,
              8'h00, 8'h02, 8'hff,
              TAG_CLASS};
      set_pool_count(16'd21);
      foreach (seq[i]) push_byte(seq[i], i == 0);
      flush_stim();
   endtask

   // Long or double in the last slot ends the pool.
   task automatic test_two_slot_end();
      logic [7:0] seq [$];
      set_pool_count(16'd4);
      seq = '{TAG_INTEGER, 8'h01, 8'h02, 8'h03, 8'h04,
              TAG_CLASS, 8'h00, 8'h05,
              TAG_LONG, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef,
              TAG_CLASS, 8'h00, 8'h01};
      foreach (seq[i]) push_byte(seq[i], i == 0);
      flush_stim();
      set_pool_count(16'd3);
      seq = '{TAG_DOUBLE, 8'hfe, 8'hdc, 8'hba, 8'h98, 8'h76, 8'h54, 8'h32, 8'h10,
              TAG_LONG, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
      foreach (seq[i]) push_byte(seq[i], i == 0);
      flush_stim();
   endtask

   // first_byte mid-field and mid-text, a count change mid-pool, and a
   // restart after the pool has finished.
   task automatic test_restart();
      set_pool_count(16'hffff);
      push_byte(TAG_INTEGER, 1'b1);
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      push_byte(TAG_CLASS, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h07, 1'b0);
      push_byte(TAG_UTF8, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(TAG_METHODHDL, 1'b1);
      push_byte(8'h05, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h09, 1'b0);
      flush_stim();
      // slot 2 now; the smaller count ends the pool after one more entry
      set_pool_count(16'd3);
      push_entry(TAG_STRING, 1'b0);
      push_entry(TAG_CLASS, 1'b0);
      flush_stim();
      set_pool_count(16'd2);
      push_entry(TAG_CLASS, 1'b1);
      push_entry(TAG_CLASS, 1'b0);
      push_entry(TAG_NAMETYPE, 1'b1);
      flush_stim();
   endtask

   // Slot numbers past 255: a long run of error entries that ends the pool.
   task automatic test_long_pool();
      set_pool_count(16'd258);
      for (int i = 0; i < 260; i++) push_byte(8'($urandom_range(19, 255)), i == 0);
      flush_stim();
   endtask

   // Random pools: mostly well-formed entries with random content, some
   // truncated entries followed by a restart, and some noise bytes.
   task automatic test_random_pools();
      int          start;
      int          pick;
      logic        f;
      logic [15:0] cnt;
      start = live_bytes;
      while (live_bytes - start < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0:       cnt = 16'($urandom_range(0, 1));
            1:       cnt = 16'hffff;
            2:       cnt = 16'($urandom_range(0, 65535));
            default: cnt = 16'($urandom_range(2, 24));
         endcase
         set_pool_count(cnt);
         gaps_on = ($urandom_range(0, 3) != 0);
         f = ($urandom_range(0, 7) != 0);
         repeat ($urandom_range(1, 20)) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               repeat ($urandom_range(1, 4))
                  push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
               push_entry(pick_tag(), f);
               f = 1'b0;
               if (pick == 1) begin
                  // cut the entry short and restart on the next one
                  repeat ($urandom_range(1, 3))
                     if (stim_q.size() > 1) void'(stim_q.pop_back());
                  f = 1'b1;
               end
            end
         end
         flush_stim();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checking
   // ---------------------------------------------------------------------
   int       ready_run = 0;
   int       ready_mode = 0;

   // Receiver modes held for a random stretch: always ready, mostly ready,
   // mostly stalled, and long periodic stalls.
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_run  <= $urandom_range(20, 200);
      end else begin
         ready_run <= ready_run - 1;
      end
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (ready_run[3:0] < 4'd3);
      endcase
   end

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      pool_result_type want;
      rsp_data_type d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         d = rsp_tdata;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none actual tdata %h tuser %h tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", 64'(want.kind), 64'(rsp_tuser[1:0]));
            compare_field("entry_index", 64'(want.entry_index), 64'(d.entry_index));
            compare_field("tag", 64'(want.tag), 64'(d.tag));
            compare_field("value", want.value, d.value);
            compare_field("index_first", 64'(want.index_first), 64'(d.index_first));
            compare_field("index_second", 64'(want.index_second), 64'(d.index_second));
            compare_field("ref_kind", 64'(want.ref_kind), 64'(d.ref_kind));
            compare_field("text_byte", 64'(want.text_byte), 64'(d.text_byte));
            compare_field("entry_end", 64'(want.entry_end), 64'(rsp_tlast));
            compare_field("pool_done", 64'(want.pool_done), 64'(rsp_tuser[2]));
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of tests
   // ---------------------------------------------------------------------
   initial begin
      restart_parse();
      pool_cnt = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_pool();
      test_all_tags();
      test_two_slot_end();
      test_restart();
      test_long_pool();
      test_random_pools();
      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
design/ccpp_pkg.sv
design/class_constant_pool_parser_top.sv
test/tb.sv
